// ----- src/phc_pkg.sv -----
// ----------------------------------------------------------------------------
// phc_pkg
// shared types, constants and helper functions for the png header checker
// ----------------------------------------------------------------------------
package phc_pkg;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_EMPTY       = 4'd1,
        ST_SHORT       = 4'd2,
        ST_SIGNATURE   = 4'd3,
        ST_NO_IHDR     = 4'd4,
        ST_CRC         = 4'd5,
        ST_COMPRESSION = 4'd6,
        ST_FILTER      = 4'd7,
        ST_INTERLACE   = 4'd8,
        ST_COLOUR      = 4'd9,
        ST_DEPTH       = 4'd10
    } status_t;

    localparam int          PosWidth   = 6;
    localparam logic [5:0]  PosSigEnd  = 6'd7;
    localparam logic [5:0]  PosTypeLo  = 6'd12;
    localparam logic [5:0]  PosTypeHi  = 6'd15;
    localparam logic [5:0]  PosWidthLo = 6'd16;
    localparam logic [5:0]  PosWidthHi = 6'd19;
    localparam logic [5:0]  PosHgtLo   = 6'd20;
    localparam logic [5:0]  PosHgtHi   = 6'd23;
    localparam logic [5:0]  PosDepth   = 6'd24;
    localparam logic [5:0]  PosColour  = 6'd25;
    localparam logic [5:0]  PosCompr   = 6'd26;
    localparam logic [5:0]  PosFilter  = 6'd27;
    localparam logic [5:0]  PosIntl    = 6'd28;
    localparam logic [5:0]  PosCrcLo   = 6'd29;
    localparam logic [5:0]  PosCrcHi   = 6'd32;
    localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0: v = 8'd137;
            3'd1: v = 8'd80;
            3'd2: v = 8'd78;
            3'd3: v = 8'd71;
            3'd4: v = 8'd13;
            3'd5: v = 8'd10;
            3'd6: v = 8'd26;
            3'd7: v = 8'd10;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'd73;
            2'd1: v = 8'd72;
            2'd2: v = 8'd68;
            2'd3: v = 8'd82;
        endcase
        return v;
    endfunction

    // reflected crc-32, one byte folded in bit by bit
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    function automatic status_t colour_check(input logic [7:0] ct, input logic [7:0] bd);
        logic    ok;
        status_t st;
        ok = 1'b0;
        st = ST_OK;
        unique case (ct)
            8'd0: ok = (bd == 8'd1) || (bd == 8'd2) || (bd == 8'd4) || (bd == 8'd8)
                       || (bd == 8'd16);
            8'd2, 8'd4, 8'd6: ok = (bd == 8'd8) || (bd == 8'd16);
            8'd3: ok = (bd == 8'd1) || (bd == 8'd2) || (bd == 8'd4) || (bd == 8'd8);
            default: st = ST_COLOUR;
        endcase
        if (st != ST_COLOUR)
        begin
            st = ok ? ST_OK : ST_DEPTH;
        end
        return st;
    endfunction

endpackage

// ----- src/png_header_checker.sv -----
// ----------------------------------------------------------------------------
// png_header_checker
// byte-wide png signature and ihdr parser with header crc-32 check
// ----------------------------------------------------------------------------
// output: registered, valid the cycle after the byte transaction causing it
// throughput: one byte per cycle unless a stalled result holds off the input;
//   crc update and field capture are combinational ahead of the output register
// reset (rst_n low, asynchronous): stream state cleared, crc preset to all ones,
//   crc checking enabled, no result pending
module png_header_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        skip_crc_check,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        empty_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [7:0]  bit_depth,
    output logic [7:0]  colour_kind,
    output logic [7:0]  interlaced
);
    import phc_pkg::*;

    logic                skip_reg;
    logic [PosWidth-1:0] pos_reg, pos_next;
    logic [31:0]         crc_reg, crc_next;
    logic [31:0]         rcrc_reg, rcrc_next;
    logic [31:0]         width_reg, width_next;
    logic [31:0]         height_reg, height_next;
    logic [7:0]          depth_reg, depth_next;
    logic [7:0]          colour_reg, colour_next;
    logic [7:0]          compr_reg, compr_next;
    logic [7:0]          filter_reg, filter_next;
    logic [7:0]          intl_reg, intl_next;
    logic                sig_ok_reg, sig_ok_next;
    logic                type_ok_reg, type_ok_next;
    logic                decided_reg, decided_next;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [31:0]         owidth_reg, oheight_reg;
    logic [7:0]          odepth_reg, ocolour_reg, ointl_reg;

    logic                in_fire;
    logic                res_valid;
    logic                res_fields;
    status_t             res_status;
    logic [31:0]         res_width, res_height;
    logic [7:0]          res_depth, res_colour, res_intl;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        logic    clear;
        logic    done;
        logic    check_crc;
        logic [31:0] w_u, h_u, rc_u, crc_u;
        logic [7:0]  d_u, c_u, cm_u, f_u, i_u;
        logic        s_u, t_u;

        clear      = 1'b0;
        done       = 1'b0;
        check_crc  = 1'b0;
        res_valid  = 1'b0;
        res_fields = 1'b0;
        res_status = ST_OK;
        w_u  = width_reg;
        h_u  = height_reg;
        rc_u = rcrc_reg;
        crc_u = crc_reg;
        d_u  = depth_reg;
        c_u  = colour_reg;
        cm_u = compr_reg;
        f_u  = filter_reg;
        i_u  = intl_reg;
        s_u  = sig_ok_reg;
        t_u  = type_ok_reg;
        pos_next     = pos_reg;
        decided_next = decided_reg;

        if (in_fire)
        begin
            if (empty_stream)
            begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
                clear      = 1'b1;
            end
            else if (decided_reg)
            begin
                clear = last_byte;
            end
            else
            begin
                if (pos_reg <= PosSigEnd)
                begin
                    if (data_byte != sig_byte(pos_reg[2:0]))
                        s_u = 1'b0;
                end
                else if (pos_reg >= PosTypeLo && pos_reg <= PosTypeHi)
                begin
                    if (data_byte != ihdr_byte(pos_reg[1:0]))
                        t_u = 1'b0;
                end
                else if (pos_reg >= PosWidthLo && pos_reg <= PosWidthHi)
                    w_u = {width_reg[23:0], data_byte};
                else if (pos_reg >= PosHgtLo && pos_reg <= PosHgtHi)
                    h_u = {height_reg[23:0], data_byte};
                else if (pos_reg == PosDepth)
                    d_u = data_byte;
                else if (pos_reg == PosColour)
                    c_u = data_byte;
                else if (pos_reg == PosCompr)
                    cm_u = data_byte;
                else if (pos_reg == PosFilter)
                    f_u = data_byte;
                else if (pos_reg == PosIntl)
                    i_u = data_byte;
                else if (pos_reg >= PosCrcLo && pos_reg <= PosCrcHi)
                    rc_u = {rcrc_reg[23:0], data_byte};

                if (pos_reg >= PosTypeLo && pos_reg <= PosIntl)
                    crc_u = crc_byte(crc_reg, data_byte);

                if (pos_reg == PosIntl && skip_reg)
                    done = 1'b1;
                else if (pos_reg == PosCrcHi)
                begin
                    done      = 1'b1;
                    check_crc = 1'b1;
                end

                if (done)
                begin
                    res_valid = 1'b1;
                    // checks in the order below, first failure wins
                    priority if (!s_u)
                        res_status = ST_SIGNATURE;
                    else if (!t_u)
                        res_status = ST_NO_IHDR;
                    else if (check_crc && (rc_u != ~crc_u))
                        res_status = ST_CRC;
                    else if (cm_u != 8'd0)
                        res_status = ST_COMPRESSION;
                    else if (f_u != 8'd0)
                        res_status = ST_FILTER;
                    else if (i_u > 8'd1)
                        res_status = ST_INTERLACE;
                    else
                        res_status = colour_check(c_u, d_u);
                    res_fields = s_u && t_u;
                    if (last_byte)
                        clear = 1'b1;
                    else
                        decided_next = 1'b1;
                end
                else if (last_byte)
                begin
                    res_valid  = 1'b1;
                    res_status = ST_SHORT;
                    clear      = 1'b1;
                end
                else
                    pos_next = pos_reg + 1'b1;
            end
        end

        // owidth etc. take the updated values before any clear
        res_width   = res_fields ? w_u : 32'd0;
        res_height  = res_fields ? h_u : 32'd0;
        res_depth   = res_fields ? d_u : 8'd0;
        res_colour  = res_fields ? c_u : 8'd0;
        res_intl    = res_fields ? i_u : 8'd0;
        width_next  = w_u;
        height_next = h_u;
        depth_next  = d_u;
        colour_next = c_u;
        intl_next   = i_u;
        rcrc_next   = rc_u;
        crc_next    = crc_u;
        compr_next  = cm_u;
        filter_next = f_u;
        sig_ok_next  = s_u;
        type_ok_next = t_u;
        if (clear)
        begin
            pos_next     = '0;
            crc_next     = CrcInit;
            rcrc_next    = '0;
            width_next   = '0;
            height_next  = '0;
            depth_next   = '0;
            colour_next  = '0;
            compr_next   = '0;
            filter_next  = '0;
            intl_next    = '0;
            sig_ok_next  = 1'b1;
            type_ok_next = 1'b1;
            decided_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg    <= 1'b0;
            pos_reg     <= '0;
            crc_reg     <= CrcInit;
            rcrc_reg    <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            depth_reg   <= '0;
            colour_reg  <= '0;
            compr_reg   <= '0;
            filter_reg  <= '0;
            intl_reg    <= '0;
            sig_ok_reg  <= 1'b1;
            type_ok_reg <= 1'b1;
            decided_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                skip_reg <= skip_crc_check;
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            rcrc_reg    <= rcrc_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            depth_reg   <= depth_next;
            colour_reg  <= colour_next;
            compr_reg   <= compr_next;
            filter_reg  <= filter_next;
            intl_reg    <= intl_next;
            sig_ok_reg  <= sig_ok_next;
            type_ok_reg <= type_ok_next;
            decided_reg <= decided_next;
            if (in_fire && res_valid)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            status_reg  <= res_status;
            owidth_reg  <= res_width;
            oheight_reg <= res_height;
            odepth_reg  <= res_depth;
            ocolour_reg <= res_colour;
            ointl_reg   <= res_intl;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign image_width  = owidth_reg;
    assign image_height = oheight_reg;
    assign bit_depth    = odepth_reg;
    assign colour_kind  = ocolour_reg;
    assign interlaced   = ointl_reg;

endmodule

// ----- src/phc_checker.sv -----
// ----------------------------------------------------------------------------
// phc_checker
// port-level assertions for the png header checker, bound to the top level
// ----------------------------------------------------------------------------
module phc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        empty_stream,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic [31:0] image_width,
    input logic [31:0] image_height,
    input logic [7:0]  bit_depth,
    input logic [7:0]  colour_kind,
    input logic [7:0]  interlaced
);
    import phc_pkg::*;

    // a stalled result holds its status and width
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(image_width))
        else $error("result changed while stalled");

    // input only back-pressured by a stalled result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a pending result");

    // an empty-stream transaction yields an empty status next cycle
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && empty_stream |=> out_valid && (status == ST_EMPTY))
        else $error("empty stream not reported");

    // early-failure statuses carry zeroed fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == ST_EMPTY) || (status == ST_SHORT)
                      || (status == ST_SIGNATURE) || (status == ST_NO_IHDR))
        |-> (image_width == 32'd0) && (image_height == 32'd0) && (bit_depth == 8'd0)
            && (colour_kind == 8'd0) && (interlaced == 8'd0))
        else $error("fields not cleared on early failure");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_DEPTH)
        else $error("status code out of range");

endmodule

bind png_header_checker phc_checker u_phc_checker (.*);
